// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They compile away in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PTSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PTSA_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PTSA_ASSERT(lbl, prop, msg)
`define PTSA_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/ptsa_pkg.sv =====
// ---------------------------------------------------------------------------
// ptsa_pkg
// Types and constants shared by the transmit scheduler modules.
// ---------------------------------------------------------------------------
package ptsa_pkg;

    localparam int QUEUE_SLOTS_DEF = 8;

    localparam int TIME_W     = 32;
    localparam int WIN_W      = 22;
    localparam int PCT_W      = 7;
    localparam int PRE_W      = 8;
    localparam int PB_W       = 6;
    localparam int AIR_W      = 14;
    localparam int TAG_W      = 8;
    localparam int LEN_W      = 8;
    localparam int DLY_W      = 16;
    localparam int PRIO_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;
    localparam int PROD_W     = WIN_W + PCT_W;
    localparam int SUM_W      = TIME_W + 1;
    localparam int SUM100_W   = SUM_W + 7;

    localparam logic [PRIO_W-1:0] PRIO_NEVER = 8'd255;

    localparam logic OP_ENQ  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [WIN_W-1:0] WINDOW_RST   = 22'd60000;
    localparam logic [PCT_W-1:0] BUDGET_RST   = 7'd10;
    localparam logic [PRE_W-1:0] PREAMBLE_RST = 8'd15;
    localparam logic [PB_W-1:0]  PER_BYTE_RST = 6'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW   = 2'd0,
        CFG_BUDGET   = 2'd1,
        CFG_PREAMBLE = 2'd2,
        CFG_PER_BYTE = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic enq;
        logic tick;
        logic scan_init;
        logic scan_step;
        logic air;
        logic sum;
        logic fin;
        logic res_clear;
        logic load_out;
    } ptsa_cmd_t;

    typedef struct packed {
        logic silent;
        logic scan_done;
        logic best_found;
    } ptsa_status_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] release_ms;
        logic [PRIO_W-1:0] prio;
    } ptsa_slot_t;

endpackage

// ===== design/priority_tx_scheduler_airtime.sv =====
// ---------------------------------------------------------------------------
// priority_tx_scheduler_airtime
// Priority transmit scheduler with silence gap and windowed airtime budget.
// ---------------------------------------------------------------------------
// The input channel (in_valid/in_ready) carries one item: an enqueue (op 0)
// or a one millisecond tick with a scheduling pass (op 1). Every item gives
// exactly one result item on the output channel (out_valid/out_ready).
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready; the user must write it only while the block is idle, which
// the block itself does not enforce. One item is worked on at a time. An
// enqueue goes straight to the done state. A tick first checks the silence
// gap and ends there inside it; otherwise it scans the slot memory, one slot
// per cycle on its single read port, and ends there if no ready packet is
// found, else it passes the airtime, sum and finish states. The next item can
// be accepted in the cycle after the result is handed to the output register,
// so results may wait while the next item runs. When the receiver stalls, the
// result stays in the output register and the following result is held until
// that one is taken.
// Reset empties the queue, clears the time and airtime state and loads the
// default configuration; no clearing pass is needed.
// ---------------------------------------------------------------------------
module priority_tx_scheduler_airtime #(
    parameter int QUEUE_SLOTS = ptsa_pkg::QUEUE_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            op,
    input  logic [ptsa_pkg::TAG_W-1:0]      packet_tag,
    input  logic [ptsa_pkg::LEN_W-1:0]      pkt_bytes,
    input  logic [ptsa_pkg::DLY_W-1:0]      wait_ms,
    input  logic [ptsa_pkg::PRIO_W-1:0]     prio,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            accepted,
    output logic                            tx_valid,
    output logic [ptsa_pkg::TAG_W-1:0]      tx_tag,
    output logic [ptsa_pkg::LEN_W-1:0]      tx_len,
    output logic [ptsa_pkg::AIR_W-1:0]      tx_airtime,
    output logic                            budget_blocked,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ptsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ptsa_pkg::CFG_DATA_W-1:0] cfg_data
);

    ptsa_pkg::ptsa_cmd_t    cmd;
    ptsa_pkg::ptsa_status_t st;

    ptsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_op     (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    ptsa_dp #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .packet_tag     (packet_tag),
        .pkt_bytes      (pkt_bytes),
        .wait_ms        (wait_ms),
        .prio           (prio),
        .cmd            (cmd),
        .st             (st),
        .accepted       (accepted),
        .tx_valid       (tx_valid),
        .tx_tag         (tx_tag),
        .tx_len         (tx_len),
        .tx_airtime     (tx_airtime),
        .budget_blocked (budget_blocked)
    );

endmodule

// ===== design/ptsa_ctrl.sv =====
// ---------------------------------------------------------------------------
// ptsa_ctrl
// Sequencer for enqueue and tick items; owns the input and output handshakes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ptsa_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    in_op,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  ptsa_pkg::ptsa_status_t  st,
    output ptsa_pkg::ptsa_cmd_t     cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_GAP  = 7'b0000010,
        S_SCAN = 7'b0000100,
        S_AIR  = 7'b0001000,
        S_SUM  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_op == ptsa_pkg::OP_TICK)
                    begin
                        cmd.tick   = 1'b1;
                        state_next = S_GAP;
                    end
                    else
                    begin
                        cmd.enq    = 1'b1;
                        state_next = S_DONE;
                    end
                end
            end
            S_GAP:
            begin
                if (st.silent)
                begin
                    cmd.res_clear = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!st.scan_done)
                begin
                    cmd.scan_step = 1'b1;
                end
                else if (st.best_found)
                begin
                    state_next = S_AIR;
                end
                else
                begin
                    cmd.res_clear = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_AIR:
            begin
                cmd.air    = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `PTSA_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath command at once")
    `PTSA_ASSERT(a_one_item, (in_valid && in_ready) |=> !in_ready, "second item taken while busy")
    `PTSA_ASSERT(a_load_valid, cmd.load_out |=> out_valid_reg, "result loaded but not presented")

endmodule

// ===== design/ptsa_dp.sv =====
// ---------------------------------------------------------------------------
// ptsa_dp
// Slot store, time and airtime registers, slot scan and budget arithmetic.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ptsa_dp #(
    parameter int QUEUE_SLOTS = ptsa_pkg::QUEUE_SLOTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ptsa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptsa_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [ptsa_pkg::TAG_W-1:0]          packet_tag,
    input  logic [ptsa_pkg::LEN_W-1:0]          pkt_bytes,
    input  logic [ptsa_pkg::DLY_W-1:0]          wait_ms,
    input  logic [ptsa_pkg::PRIO_W-1:0]         prio,
    input  ptsa_pkg::ptsa_cmd_t                 cmd,
    output ptsa_pkg::ptsa_status_t              st,
    output logic                                accepted,
    output logic                                tx_valid,
    output logic [ptsa_pkg::TAG_W-1:0]          tx_tag,
    output logic [ptsa_pkg::LEN_W-1:0]          tx_len,
    output logic [ptsa_pkg::AIR_W-1:0]          tx_airtime,
    output logic                                budget_blocked
);

    localparam int IDX_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int CNT_W = $clog2(QUEUE_SLOTS + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(QUEUE_SLOTS);

    logic [ptsa_pkg::WIN_W-1:0]    win_reg;
    logic [ptsa_pkg::PCT_W-1:0]    pct_reg;
    logic [ptsa_pkg::PRE_W-1:0]    pre_reg;
    logic [ptsa_pkg::PB_W-1:0]     pb_reg;

    logic [QUEUE_SLOTS-1:0]        slot_valid_reg;
    ptsa_pkg::ptsa_slot_t          slot_mem [QUEUE_SLOTS];

    logic [ptsa_pkg::TIME_W-1:0]   now_reg;
    logic [ptsa_pkg::TIME_W-1:0]   win_start_reg;
    logic [ptsa_pkg::TIME_W-1:0]   used_reg;
    logic [ptsa_pkg::AIR_W-1:0]    last_air_reg;
    logic [ptsa_pkg::TIME_W-1:0]   last_tx_reg;

    logic [CNT_W-1:0]              cnt_reg;
    logic                          q_vld_reg;
    logic [IDX_W-1:0]              q_idx_reg;
    ptsa_pkg::ptsa_slot_t          q_reg;
    logic                          best_found_reg;
    logic [ptsa_pkg::PRIO_W-1:0]   best_prio_reg;
    logic [IDX_W-1:0]              best_idx_reg;
    logic [ptsa_pkg::TAG_W-1:0]    best_tag_reg;
    logic [ptsa_pkg::LEN_W-1:0]    best_len_reg;

    logic [ptsa_pkg::PROD_W-1:0]   prod_reg;
    logic [ptsa_pkg::AIR_W-1:0]    air_reg;
    logic [ptsa_pkg::SUM100_W-1:0] sum100_reg;

    logic                          res_accepted_reg;
    logic                          res_tx_valid_reg;
    logic [ptsa_pkg::TAG_W-1:0]    res_tag_reg;
    logic [ptsa_pkg::LEN_W-1:0]    res_len_reg;
    logic [ptsa_pkg::AIR_W-1:0]    res_air_reg;
    logic                          res_blocked_reg;

    logic                          out_accepted_reg;
    logic                          out_tx_valid_reg;
    logic [ptsa_pkg::TAG_W-1:0]    out_tag_reg;
    logic [ptsa_pkg::LEN_W-1:0]    out_len_reg;
    logic [ptsa_pkg::AIR_W-1:0]    out_air_reg;
    logic                          out_blocked_reg;

    logic                          free_any;
    logic [IDX_W-1:0]              free_idx;
    logic                          q_hit;
    logic                          over;
    logic [ptsa_pkg::AIR_W:0]      silence;
    logic [ptsa_pkg::AIR_W-1:0]    air_calc;
    logic [ptsa_pkg::SUM_W-1:0]    sum;
    logic                          rollover;

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = QUEUE_SLOTS - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign silence = {last_air_reg, 1'b0};
    assign st.silent = (last_air_reg != '0)
                    && ((now_reg - last_tx_reg) < ptsa_pkg::TIME_W'(silence));
    assign st.scan_done  = (cnt_reg == CNT_END) && !q_vld_reg;
    assign st.best_found = best_found_reg;

    assign q_hit = q_vld_reg && slot_valid_reg[q_idx_reg]
                && (now_reg >= q_reg.release_ms) && (q_reg.prio < best_prio_reg);

    assign air_calc = ptsa_pkg::AIR_W'(best_len_reg) * ptsa_pkg::AIR_W'(pb_reg)
                    + ptsa_pkg::AIR_W'(pre_reg);
    assign rollover = (now_reg - win_start_reg) >= ptsa_pkg::TIME_W'(win_reg);
    assign sum = ptsa_pkg::SUM_W'(used_reg) + ptsa_pkg::SUM_W'(air_reg);
    assign over = sum100_reg > ptsa_pkg::SUM100_W'(prod_reg);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.enq && free_any)
        begin
            slot_mem[free_idx] <= '{tag:        packet_tag,
                                    len:        pkt_bytes,
                                    release_ms: now_reg + ptsa_pkg::TIME_W'(wait_ms),
                                    prio:       prio};
        end
        if (cmd.scan_step && (cnt_reg != CNT_END))
        begin
            q_reg <= slot_mem[cnt_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg        <= ptsa_pkg::WINDOW_RST;
            pct_reg        <= ptsa_pkg::BUDGET_RST;
            pre_reg        <= ptsa_pkg::PREAMBLE_RST;
            pb_reg         <= ptsa_pkg::PER_BYTE_RST;
            slot_valid_reg <= '0;
            now_reg        <= '0;
            win_start_reg  <= '0;
            used_reg       <= '0;
            last_air_reg   <= '0;
            last_tx_reg    <= '0;
            cnt_reg        <= '0;
            q_vld_reg      <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (ptsa_pkg::cfg_idx_t'(cfg_index))
                    ptsa_pkg::CFG_WINDOW:   win_reg <= cfg_data;
                    ptsa_pkg::CFG_BUDGET:   pct_reg <= cfg_data[ptsa_pkg::PCT_W-1:0];
                    ptsa_pkg::CFG_PREAMBLE: pre_reg <= cfg_data[ptsa_pkg::PRE_W-1:0];
                    ptsa_pkg::CFG_PER_BYTE: pb_reg  <= cfg_data[ptsa_pkg::PB_W-1:0];
                    default:                win_reg <= win_reg;
                endcase
            end
            if (cmd.enq && free_any)
            begin
                slot_valid_reg[free_idx] <= 1'b1;
            end
            if (cmd.tick)
            begin
                now_reg <= now_reg + ptsa_pkg::TIME_W'(1);
            end
            if (cmd.scan_init)
            begin
                cnt_reg        <= '0;
                q_vld_reg      <= 1'b0;
                best_found_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                if (cnt_reg != CNT_END)
                begin
                    cnt_reg   <= cnt_reg + CNT_W'(1);
                    q_vld_reg <= 1'b1;
                end
                else
                begin
                    q_vld_reg <= 1'b0;
                end
                if (q_hit)
                begin
                    best_found_reg <= 1'b1;
                end
            end
            if (cmd.air && rollover)
            begin
                win_start_reg <= now_reg;
                used_reg      <= '0;
            end
            if (cmd.fin && !over)
            begin
                used_reg                     <= used_reg + ptsa_pkg::TIME_W'(air_reg);
                last_air_reg                 <= air_reg;
                last_tx_reg                  <= now_reg;
                slot_valid_reg[best_idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick)
        begin
            prod_reg <= ptsa_pkg::PROD_W'(win_reg) * ptsa_pkg::PROD_W'(pct_reg);
        end
        if (cmd.scan_init)
        begin
            best_prio_reg <= ptsa_pkg::PRIO_NEVER;
        end
        if (cmd.scan_step)
        begin
            q_idx_reg <= cnt_reg[IDX_W-1:0];
            if (q_hit)
            begin
                best_prio_reg <= q_reg.prio;
                best_idx_reg  <= q_idx_reg;
                best_tag_reg  <= q_reg.tag;
                best_len_reg  <= q_reg.len;
            end
        end
        if (cmd.air)
        begin
            air_reg <= air_calc;
        end
        if (cmd.sum)
        begin
            sum100_reg <= ptsa_pkg::SUM100_W'({sum, 6'b0})
                        + ptsa_pkg::SUM100_W'({sum, 5'b0})
                        + ptsa_pkg::SUM100_W'({sum, 2'b0});
        end
        if (cmd.enq || cmd.res_clear || cmd.fin)
        begin
            res_accepted_reg <= cmd.enq && free_any;
            res_tx_valid_reg <= cmd.fin && !over;
            res_tag_reg      <= (cmd.fin && !over) ? best_tag_reg : '0;
            res_len_reg      <= (cmd.fin && !over) ? best_len_reg : '0;
            res_air_reg      <= (cmd.fin && !over) ? air_reg : '0;
            res_blocked_reg  <= cmd.fin && over;
        end
        if (cmd.load_out)
        begin
            out_accepted_reg <= res_accepted_reg;
            out_tx_valid_reg <= res_tx_valid_reg;
            out_tag_reg      <= res_tag_reg;
            out_len_reg      <= res_len_reg;
            out_air_reg      <= res_air_reg;
            out_blocked_reg  <= res_blocked_reg;
        end
    end

    assign accepted       = out_accepted_reg;
    assign tx_valid       = out_tx_valid_reg;
    assign tx_tag         = out_tag_reg;
    assign tx_len         = out_len_reg;
    assign tx_airtime     = out_air_reg;
    assign budget_blocked = out_blocked_reg;

    `PTSA_ASSERT(a_enq_fills, (cmd.enq && free_any) |=> ($countones(slot_valid_reg) == $past($countones(slot_valid_reg)) + 1), "enqueue did not occupy one slot")
    `PTSA_ASSERT(a_issue_frees, (cmd.fin && !over) |=> !slot_valid_reg[$past(best_idx_reg)], "issued slot still occupied")
    `PTSA_NEVER(a_res_mixed, cmd.load_out && res_accepted_reg && (res_tx_valid_reg || res_blocked_reg), "enqueue result carries transmit fields")

endmodule
